### rtl/dbpst_pkg.sv
// Package for the DAG best-path score and traceback block.
// Holds request/result/row types, table sizing and saturation helpers; no dependencies.
package dbpst_pkg;

  localparam int MAX_NODES  = 64;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int LINK_W     = NODE_W + 1;
  localparam int SCORE_W    = 32;
  localparam int OWN_LEN_W  = 16;
  localparam int LEN_W      = 24;

  localparam logic [LINK_W-1:0] LINK_NONE = {LINK_W{1'b1}};
  localparam logic [LEN_W-1:0]  LEN_MAX   = {LEN_W{1'b1}};

  typedef struct packed {
    logic signed [31:0] node_score;
    logic [15:0]        node_len;
    logic [5:0]         successor;
    logic               has_successor;
    logic               last_of_node;
    logic               last_of_graph;
  } dbpst_item_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] best_total;
    logic [5:0]         chain_node;
    logic [23:0]        chain_prefix_length;
    logic [23:0]        chain_thru_length;
    logic               last;
  } dbpst_result_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] best_prefix;
    logic [LINK_W-1:0]         back_link;
    logic [LEN_W-1:0]          prefix_len;
  } dbpst_row_t;

  localparam dbpst_row_t ROW_RESET = '{best_prefix: '0, back_link: LINK_NONE,
                                       prefix_len: '0};

  function automatic logic signed [SCORE_W-1:0] sat_score(
    input logic signed [SCORE_W-1:0] a,
    input logic signed [SCORE_W-1:0] b
  );
    logic signed [SCORE_W:0] s;
    s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
    if (s[SCORE_W] != s[SCORE_W-1]) begin
      sat_score = s[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
    end else begin
      sat_score = s[SCORE_W-1:0];
    end
  endfunction

  function automatic logic [LEN_W-1:0] sat_len(
    input logic [LEN_W-1:0]     a,
    input logic [OWN_LEN_W-1:0] b
  );
    logic [LEN_W:0] s;
    s = {1'b0, a} + {{(LEN_W + 1 - OWN_LEN_W){1'b0}}, b};
    sat_len = s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
  endfunction

endpackage

### rtl/dbpst_table.sv
// Per-node tables: score/link/prefix-length rows with valid bits, and own-length memory.
// Depends on dbpst_pkg. Two registered row read ports, one row write port.
module dbpst_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             clear,
  input  logic [dbpst_pkg::NODE_W-1:0]     rd_a_addr,
  input  logic [dbpst_pkg::NODE_W-1:0]     rd_b_addr,
  output dbpst_pkg::dbpst_row_t            rd_a_row,
  output dbpst_pkg::dbpst_row_t            rd_b_row,
  input  logic                             wr_en,
  input  logic [dbpst_pkg::NODE_W-1:0]     wr_addr,
  input  dbpst_pkg::dbpst_row_t            wr_row,
  input  logic                             own_wr_en,
  input  logic [dbpst_pkg::NODE_W-1:0]     own_wr_addr,
  input  logic [dbpst_pkg::OWN_LEN_W-1:0]  own_wr_data,
  input  logic [dbpst_pkg::NODE_W-1:0]     own_rd_addr,
  output logic [dbpst_pkg::OWN_LEN_W-1:0]  own_rd_data
);
  import dbpst_pkg::*;

  dbpst_row_t             rows [MAX_NODES];
  logic [OWN_LEN_W-1:0]   own_mem [MAX_NODES];
  logic [MAX_NODES-1:0]   valid;
  dbpst_row_t             a_q;
  dbpst_row_t             b_q;
  logic                   a_valid;
  logic                   b_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rows[wr_addr] <= wr_row;
    end
    a_q     <= rows[rd_a_addr];
    b_q     <= rows[rd_b_addr];
    a_valid <= valid[rd_a_addr];
    b_valid <= valid[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (own_wr_en) begin
      own_mem[own_wr_addr] <= own_wr_data;
    end
    own_rd_data <= own_mem[own_rd_addr];
  end

  assign rd_a_row = a_valid ? a_q : ROW_RESET;
  assign rd_b_row = b_valid ? b_q : ROW_RESET;

endmodule

### rtl/dag_best_path_score_traceback.sv
// Top level of the DAG best-path score block with end-of-graph traceback.
// Depends on dbpst_pkg and dbpst_table.
//
//   channel   signals              direction  meaning
//   request   start, busy, item    in         one edge or sink marker of the current node
//   result    strobe, result       out        one traceback node per strobe, single cycle
//
// Each request passes through a table read of the current and target rows (S_READ),
// then one saturating add/compare pass with a read-modify-write of the target row (S_UPD).
// busy is low in S_IDLE and in S_UPD unless last_of_graph, so a new request can be
// accepted while the previous one is updated. After last_of_graph: S_TSTART (a lone
// not-found result if no node ended), then a table read and an emit per chain node, then
// S_CLEAR clears the valid bits. Reset is synchronous; results cannot be stalled, each strobe lasts one cycle.
module dag_best_path_score_traceback (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  dbpst_pkg::dbpst_item_t   item,
  output logic                     strobe,
  output dbpst_pkg::dbpst_result_t result
);
  import dbpst_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ   = 7'b0000010,
    S_UPD    = 7'b0000100,
    S_TSTART = 7'b0001000,
    S_TREAD  = 7'b0010000,
    S_TEMIT  = 7'b0100000,
    S_CLEAR  = 7'b1000000
  } state_t;

  state_t                     state, state_next;
  dbpst_item_t                req;
  logic [LINK_W-1:0]          node_cnt, node_cnt_next;
  logic signed [SCORE_W-1:0]  best_score, best_score_next;
  logic [LINK_W-1:0]          best_node, best_node_next;
  logic [LINK_W-1:0]          ptr, ptr_next;
  logic                       strobe_next;
  dbpst_result_t              result_next;

  dbpst_row_t                 cur_row, succ_row, wr_row;
  logic [OWN_LEN_W-1:0]       own_q;
  logic                       accept, active, edge_ok, tbl_wr, own_wr, tbl_clear;
  logic signed [SCORE_W-1:0]  ext;
  logic [LEN_W-1:0]           len_a, len_sum;
  logic [OWN_LEN_W-1:0]       len_b;
  logic [NODE_W-1:0]          rd_a_addr;

  assign busy   = !(state == S_IDLE || (state == S_UPD && !req.last_of_graph));
  assign accept = start && !busy;
  assign active = node_cnt < LINK_W'(MAX_NODES);
  assign edge_ok = active && req.has_successor && (req.successor > node_cnt[NODE_W-1:0]);
  assign rd_a_addr = (state == S_READ) ? node_cnt[NODE_W-1:0] : ptr[NODE_W-1:0];

  dbpst_table u_table (
    .clk         (clk),
    .rst         (rst),
    .clear       (tbl_clear),
    .rd_a_addr   (rd_a_addr),
    .rd_b_addr   (req.successor),
    .rd_a_row    (cur_row),
    .rd_b_row    (succ_row),
    .wr_en       (tbl_wr),
    .wr_addr     (req.successor),
    .wr_row      (wr_row),
    .own_wr_en   (own_wr),
    .own_wr_addr (node_cnt[NODE_W-1:0]),
    .own_wr_data (req.node_len),
    .own_rd_addr (ptr[NODE_W-1:0]),
    .own_rd_data (own_q)
  );

  // shared length adder: prefix + own length, in update and in traceback
  assign len_a   = cur_row.prefix_len;
  assign len_b   = (state == S_TEMIT) ? own_q : req.node_len;
  assign len_sum = sat_len(len_a, len_b);
  assign ext     = sat_score(cur_row.best_prefix, req.node_score);

  always_comb begin
    wr_row            = succ_row;
    wr_row.prefix_len = len_sum;
    if (ext >= succ_row.best_prefix) begin
      wr_row.best_prefix = ext;
      wr_row.back_link   = {1'b0, node_cnt[NODE_W-1:0]};
    end
  end

  always_comb begin
    state_next      = state;
    node_cnt_next   = node_cnt;
    best_score_next = best_score;
    best_node_next  = best_node;
    ptr_next        = ptr;
    strobe_next     = 1'b0;
    result_next     = result;
    tbl_wr          = 1'b0;
    own_wr          = 1'b0;
    tbl_clear       = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        own_wr = active;
        tbl_wr = edge_ok;
        if (active && (req.last_of_node || req.last_of_graph)) begin
          if (ext >= best_score) begin
            best_score_next = ext;
            best_node_next  = node_cnt;
          end
          node_cnt_next = node_cnt + 1'b1;
        end
        if (req.last_of_graph) begin
          state_next = S_TSTART;
        end else if (accept) begin
          state_next = S_READ;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_TSTART: begin
        if (best_node[LINK_W-1]) begin
          result_next = '{found: 1'b0, best_total: '0, chain_node: '0,
                          chain_prefix_length: '0, chain_thru_length: '0, last: 1'b1};
          strobe_next = 1'b1;
          state_next  = S_CLEAR;
        end else begin
          ptr_next   = best_node;
          state_next = S_TREAD;
        end
      end
      S_TREAD: begin
        state_next = S_TEMIT;
      end
      S_TEMIT: begin
        result_next.found               = 1'b1;
        result_next.best_total          = best_score;
        result_next.chain_node          = ptr[NODE_W-1:0];
        result_next.chain_prefix_length = cur_row.prefix_len;
        result_next.chain_thru_length   = len_sum;
        result_next.last                = cur_row.back_link[LINK_W-1];
        strobe_next                     = 1'b1;
        ptr_next                        = cur_row.back_link;
        state_next = cur_row.back_link[LINK_W-1] ? S_CLEAR : S_TREAD;
      end
      S_CLEAR: begin
        tbl_clear       = 1'b1;
        node_cnt_next   = '0;
        best_score_next = '0;
        best_node_next  = LINK_NONE;
        state_next      = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_cnt   <= '0;
      best_score <= '0;
      best_node  <= LINK_NONE;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      node_cnt   <= node_cnt_next;
      best_score <= best_score_next;
      best_node  <= best_node_next;
      strobe     <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req <= item;
    ptr    <= ptr_next;
    result <= result_next;
  end

  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ($past(state) == S_TSTART || $past(state) == S_TEMIT))
    else $error("result strobe without traceback step");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |-> state == S_CLEAR)
    else $error("final result not followed by table clear");

  a_notfound_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.found |-> result.last)
    else $error("not-found result must be the only one");

  a_busy_trace: assert property (@(posedge clk) disable iff (rst)
    (state == S_TREAD || state == S_TEMIT || state == S_CLEAR) |-> busy)
    else $error("request accepted during traceback");

endmodule
